/* rtl/bmi_pkg.sv */
// ---------------------------------------------------------------------------
// bmi_pkg: shared types and constants for the modular inverse block
// Holds the default operand width, port widths, status codes and payloads.
// ---------------------------------------------------------------------------
package bmi_pkg;

    localparam int DEFAULT_WIDTH = 64;
    localparam int FIELD_W       = 64;
    localparam int STATUS_W      = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_ZERO    = 2'd1,
        ST_NOT_COP = 2'd2
    } status_t;

    typedef struct packed {
        logic [FIELD_W-1:0] value;
        logic [FIELD_W-1:0] modulus;
    } operands_t;

    typedef struct packed {
        logic [FIELD_W-1:0] inverse;
        status_t            status;
    } inverse_t;

endpackage

/* rtl/bmi_if.sv */
// ---------------------------------------------------------------------------
// bmi_if: valid/ready channel carrying one payload
// Generic handshake interface with source and sink views.
// ---------------------------------------------------------------------------
interface bmi_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/bmi_reduce.sv */
// ---------------------------------------------------------------------------
// bmi_reduce: restoring remainder unit
// Computes a mod m one quotient bit per cycle.
// ---------------------------------------------------------------------------
module bmi_reduce
    import bmi_pkg::*;
#(
    parameter int WIDTH = DEFAULT_WIDTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] num,
    input  logic [WIDTH-1:0] den,
    output logic             done,
    output logic [WIDTH-1:0] rem
);
    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] rem_reg, quo_reg, den_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;

    assign trial = {rem_reg, quo_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(WIDTH);
                rem_reg  <= '0;
                quo_reg  <= num;
                den_reg  <= den;
            end
            else if (busy_reg)
            begin
                quo_reg <= quo_reg << 1;
                if (!diff[WIDTH])
                    rem_reg <= diff[WIDTH-1:0];
                else
                    rem_reg <= trial[WIDTH-1:0];
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    assign rem = rem_reg;
endmodule

/* rtl/bmi_core.sv */
// ---------------------------------------------------------------------------
// bmi_core: binary extended GCD sequencer
// Runs the binary GCD on u, v with the odd operand n as the coefficient
// modulus and the other operand e, keeping u = e*x - n*y for both sides.
// ---------------------------------------------------------------------------
module bmi_core
    import bmi_pkg::*;
#(
    parameter int WIDTH = DEFAULT_WIDTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] m,
    output logic             done,
    output logic [WIDTH-1:0] inv,
    output status_t          status
);
    localparam int YW = WIDTH + 2;

    typedef enum logic { S_IDLE, S_RUN } state_t;

    state_t           state_reg;
    logic [WIDTH-1:0] u_reg, v_reg, x1_reg, x2_reg, n_reg, e_reg;
    logic [YW-1:0]    y1_reg, y2_reg;
    logic             mod_even_reg;

    // Halving x modulo an odd modulus: add the modulus when x is odd.
    function automatic logic [WIDTH-1:0] half_mod(input logic [WIDTH-1:0] x,
                                                  input logic [WIDTH-1:0] md);
        logic [WIDTH:0] s;
        begin
            s = x[0] ? ({1'b0, x} + {1'b0, md}) : {1'b0, x};
            return s[WIDTH:1];
        end
    endfunction

    // Exact signed halving of the n coefficient, which gains e whenever the
    // matching x coefficient gained n.
    function automatic logic [YW-1:0] half_y(input logic [YW-1:0]    y,
                                             input logic             odd,
                                             input logic [WIDTH-1:0] ev);
        logic [YW-1:0] s;
        begin
            s = odd ? (y + {2'b00, ev}) : y;
            return {s[YW-1], s[YW-1:1]};
        end
    endfunction

    logic             u_ge_v;
    logic [WIDTH:0]   usub, xsub;
    logic [WIDTH-1:0] x_wrap, x_sel, y_inv, inv_next;
    logic [YW-1:0]    ysub, y_wrap, y_sel, y_neg;

    assign usub   = {1'b0, u_reg} - {1'b0, v_reg};
    assign u_ge_v = !usub[WIDTH];
    assign xsub   = u_ge_v ? ({1'b0, x1_reg} - {1'b0, x2_reg})
                           : ({1'b0, x2_reg} - {1'b0, x1_reg});
    assign x_wrap = xsub[WIDTH] ? xsub[WIDTH-1:0] + n_reg : xsub[WIDTH-1:0];
    assign ysub   = u_ge_v ? (y1_reg - y2_reg) : (y2_reg - y1_reg);
    assign y_wrap = xsub[WIDTH] ? ysub + {2'b00, e_reg} : ysub;

    // With an even modulus e is the modulus and the answer is -y mod e;
    // y lies strictly between -e and e.
    assign x_sel    = (u_reg == WIDTH'(1)) ? x1_reg : x2_reg;
    assign y_sel    = (u_reg == WIDTH'(1)) ? y1_reg : y2_reg;
    assign y_neg    = -y_sel;
    assign y_inv    = (!y_sel[YW-1] && y_sel != '0) ? e_reg - y_sel[WIDTH-1:0]
                                                    : y_neg[WIDTH-1:0];
    assign inv_next = mod_even_reg ? y_inv : x_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done         <= 1'b0;
            status       <= ST_OK;
            inv          <= '0;
            u_reg        <= '0;
            v_reg        <= '0;
            x1_reg       <= '0;
            x2_reg       <= '0;
            y1_reg       <= '0;
            y2_reg       <= '0;
            n_reg        <= '0;
            e_reg        <= '0;
            mod_even_reg <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        mod_even_reg <= ~m[0];
                        if (m == '0 || a == '0)
                        begin
                            inv    <= '0;
                            status <= ST_ZERO;
                            done   <= 1'b1;
                        end
                        else if (!m[0] && !a[0])
                        begin
                            inv    <= '0;
                            status <= ST_NOT_COP;
                            done   <= 1'b1;
                        end
                        else
                        begin
                            // The odd operand serves as the coefficient modulus.
                            u_reg     <= m[0] ? a : m;
                            e_reg     <= m[0] ? a : m;
                            v_reg     <= m[0] ? m : a;
                            n_reg     <= m[0] ? m : a;
                            x1_reg    <= WIDTH'(1);
                            x2_reg    <= '0;
                            y1_reg    <= '0;
                            y2_reg    <= '1;
                            state_reg <= S_RUN;
                        end
                    end
                end
                S_RUN:
                begin
                    if (u_reg == WIDTH'(1) || v_reg == WIDTH'(1)
                        || u_reg == v_reg || v_reg == '0 || u_reg == '0)
                    begin
                        state_reg <= S_IDLE;
                        done      <= 1'b1;
                        if (u_reg == WIDTH'(1) || v_reg == WIDTH'(1))
                        begin
                            status <= ST_OK;
                            inv    <= inv_next;
                        end
                        else
                        begin
                            status <= ST_NOT_COP;
                            inv    <= '0;
                        end
                    end
                    else if (!u_reg[0])
                    begin
                        u_reg  <= u_reg >> 1;
                        x1_reg <= half_mod(x1_reg, n_reg);
                        y1_reg <= half_y(y1_reg, x1_reg[0], e_reg);
                    end
                    else if (!v_reg[0])
                    begin
                        v_reg  <= v_reg >> 1;
                        x2_reg <= half_mod(x2_reg, n_reg);
                        y2_reg <= half_y(y2_reg, x2_reg[0], e_reg);
                    end
                    else if (u_ge_v)
                    begin
                        u_reg  <= usub[WIDTH-1:0];
                        x1_reg <= x_wrap;
                        y1_reg <= y_wrap;
                    end
                    else
                    begin
                        v_reg  <= -usub[WIDTH-1:0];
                        x2_reg <= x_wrap;
                        y2_reg <= y_wrap;
                    end
                end
            endcase
        end
    end
endmodule

/* rtl/binary_modular_inverse.sv */
// ---------------------------------------------------------------------------
// binary_modular_inverse: modular inverse by binary extended GCD
// Reduces the value modulo the modulus, then runs the inverse sequencer.
// ---------------------------------------------------------------------------
// A zero modulus, zero residue or two even operands finish without GCD steps
// after the reduction; otherwise the GCD sequencer runs its steps first.
// Throughput: one transaction at a time; ready is low from acceptance until the
// cycle after the result is taken. The GCD loop in bmi_core sets the worst case.
// Reset clears the sequencers and the output valid flag.
module binary_modular_inverse
    import bmi_pkg::*;
#(
    parameter int WIDTH = DEFAULT_WIDTH
)
(
    input  logic clk,
    input  logic rst_n,
    bmi_if.sink   in_ch,
    bmi_if.source out_ch
);
    typedef enum logic [1:0] { T_IDLE, T_RED, T_GCD, T_OUT } top_state_t;
    top_state_t       state_reg;
    logic [WIDTH-1:0] m_reg;
    logic             red_done, core_done, core_start;
    logic [WIDTH-1:0] rem, inv;
    status_t          status;
    logic             accept;

    assign accept       = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = state_reg == T_IDLE;
    assign out_ch.valid = state_reg == T_OUT;
    assign core_start   = red_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= T_IDLE;
        else
        begin
            unique case (state_reg)
                T_IDLE: if (accept) state_reg <= T_RED;
                T_RED:  if (red_done) state_reg <= T_GCD;
                T_GCD:
                begin
                    if (core_done)
                    begin
                        state_reg            <= T_OUT;
                        out_ch.data.inverse  <= FIELD_W'(inv);
                        out_ch.data.status   <= status;
                    end
                end
                T_OUT:  if (out_ch.ready) state_reg <= T_IDLE;
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            m_reg <= in_ch.data.modulus[WIDTH-1:0];
    end

    // A zero modulus still runs the reduction; the sequencer flags it.
    bmi_reduce #(.WIDTH(WIDTH)) u_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .num   (in_ch.data.value[WIDTH-1:0]),
        .den   (in_ch.data.modulus[WIDTH-1:0]),
        .done  (red_done),
        .rem   (rem)
    );

    bmi_core #(.WIDTH(WIDTH)) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (core_start),
        .a      (rem),
        .m      (m_reg),
        .done   (core_done),
        .inv    (inv),
        .status (status)
    );

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.data.status != 2'd3)
        else $error("status code out of range");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.data.status != ST_OK) |-> out_ch.data.inverse == '0)
        else $error("inverse nonzero on error");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != T_IDLE) |-> !in_ch.ready)
        else $error("ready while busy");
endmodule
